// File: rtl/csdc_pkg.sv
// ----------------------------------------------------------------------------
// Clock synth divider calculator package
// Shared widths, payload words and controller/datapath interface types.
// ----------------------------------------------------------------------------
package csdc_pkg;

    localparam int FREQ_W     = 30;
    localparam int FRAC_W     = 20;
    localparam int XTAL_W     = 26;
    localparam int CLKIN_W    = 29;
    localparam int RLOG_W     = 3;
    localparam int RSHIFT_MAX = 7;
    localparam int DVD_W      = FREQ_W + FRAC_W;
    localparam int DVS_W      = FREQ_W + RSHIFT_MAX;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CLKIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_XTAL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLKIN = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [2:0]        target;
        logic [FREQ_W-1:0] frequency;
        logic              source_select;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [17:0] p1;
        logic [19:0] p2;
        logic [19:0] p3;
        logic [2:0]  rdiv_log2;
        logic        integer_only;
        logic [1:0]  prescale_log2;
    } rsp_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic check;
        logic rdiv_step;
        logic set_unreach;
        logic div_start;
        logic encode;
        logic load_out;
    } csdc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic chk_err;
        logic chk_search;
        logic srch_pass;
        logic rlog_last;
        logic div_done;
    } csdc_sts_t;

endpackage

// File: rtl/csdc_div.sv
// ----------------------------------------------------------------------------
// Clock synth divider calculator - serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csdc_div #(
    parameter int DVD_W = 50,
    parameter int DVS_W = 37
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quot_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_INIT;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            quot_next = {quot_reg[DVD_W-2:0], fits};
            rem_next  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next  = cnt_reg - CNT_LAST;
            if (cnt_reg == CNT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/csdc_dp.sv
// ----------------------------------------------------------------------------
// Clock synth divider calculator - datapath
// Configuration, request hold, range checks, R search, divider and encoding.
// ----------------------------------------------------------------------------
module csdc_dp
    import csdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  req_word_t             req_data,
    input  csdc_cmd_t             cmd,
    output csdc_sts_t             sts,
    output rsp_word_t             rsp_data
);

    typedef enum logic [1:0] {
        KIND_PLL  = 2'd0,
        KIND_INT  = 2'd1,
        KIND_FRAC = 2'd2
    } kind_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PLL_RANGE = 3'd1;
    localparam logic [2:0] ST_DIV_RANGE = 3'd2;
    localparam logic [2:0] ST_UNREACH   = 3'd3;
    localparam logic [2:0] ST_INT_RANGE = 3'd4;
    localparam logic [2:0] ST_CLKIN_HI  = 3'd5;

    localparam logic [XTAL_W-1:0]  XTAL_RST  = XTAL_W'(25000000);
    localparam logic [CLKIN_W-1:0] CLKIN_RST = CLKIN_W'(10000000);
    localparam logic [CLKIN_W-1:0] CLKIN_MAX = CLKIN_W'(40000000);
    localparam logic [FREQ_W-1:0]  PLL_MIN   = FREQ_W'(600000000);
    localparam logic [FREQ_W-1:0]  PLL_MAX   = FREQ_W'(900000000);
    localparam logic [DVS_W-1:0]   R_IN_MIN  = DVS_W'(500000);
    localparam logic [DVD_W-1:0]   FB_MIN    = DVD_W'(15) << FRAC_W;
    localparam logic [DVD_W-1:0]   FB_MAX    = DVD_W'(90) << FRAC_W;
    localparam logic [DVD_W-1:0]   IDIV_MIN  = DVD_W'(6);
    localparam logic [DVD_W-1:0]   IDIV_MAX  = DVD_W'(254);
    localparam logic [20:0]        DEN_C     = 21'h0FFFFF;
    localparam logic [17:0]        P1_OFS    = 18'd512;
    localparam int                 MS_SH     = 11;

    logic [XTAL_W-1:0]  xtal_reg;
    logic [CLKIN_W-1:0] clkin_reg;
    logic [FREQ_W-1:0]  pll_reg [2];

    req_word_t          rq_reg;
    logic [1:0]         pre_reg;
    logic               hi_reg;
    kind_t              kind_reg;
    logic [2:0]         st_reg;
    logic [RLOG_W-1:0]  rlog_reg;
    logic [DVS_W-1:0]   fr_reg;
    logic [17:0]        p1_reg;
    logic [19:0]        p2_reg;
    logic [19:0]        p3_reg;
    logic [2:0]         rd_reg;
    logic               io_reg;
    rsp_word_t          out_reg;

    logic [1:0]         pre_cur;
    logic               hi_cur;
    kind_t              kind_cur;
    logic [CLKIN_W-1:0] src;
    logic [FREQ_W-1:0]  pll_sel;
    logic [2:0]         chk_code;
    logic [DVD_W-1:0]   dvd;
    logic [DVS_W-1:0]   dvs;
    logic [DVD_W-1:0]   qt;
    logic               div_done;
    logic [FREQ_W-1:0]  fb_a;
    logic [19:0]        fb_b;
    logic [6:0]         q0;
    logic [20:0]        r0;
    logic               r_ovf;
    logic [7:0]         qf;
    logic [20:0]        rf;
    logic [17:0]        p1_frac;

    // ---- configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xtal_reg  <= XTAL_RST;
            clkin_reg <= CLKIN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_XTAL:  xtal_reg  <= cfg_data[XTAL_W-1:0];
                CFG_CLKIN: clkin_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // ---- prescaler: smallest 2^k (k at most 3) bringing the clock input to 40 MHz or less
    always_comb
    begin
        hi_cur = (clkin_reg >> 3) > CLKIN_MAX;
        if (clkin_reg <= CLKIN_MAX)
            pre_cur = 2'd0;
        else if ((clkin_reg >> 1) <= CLKIN_MAX)
            pre_cur = 2'd1;
        else if ((clkin_reg >> 2) <= CLKIN_MAX)
            pre_cur = 2'd2;
        else
            pre_cur = 2'd3;
    end

    always_comb
    begin
        if (!req_data.operation)
            kind_cur = KIND_PLL;
        else if (req_data.target > 3'd5)
            kind_cur = KIND_INT;
        else
            kind_cur = KIND_FRAC;
    end

    // ---- early checks on the held request
    assign src     = rq_reg.source_select ? (clkin_reg >> pre_reg) : CLKIN_W'(xtal_reg);
    assign pll_sel = pll_reg[rq_reg.source_select];

    always_comb
    begin
        chk_code = ST_OK;
        case (kind_reg)
            KIND_PLL:
            begin
                if (rq_reg.frequency < PLL_MIN || rq_reg.frequency > PLL_MAX)
                    chk_code = ST_PLL_RANGE;
                else if (rq_reg.source_select && hi_reg)
                    chk_code = ST_CLKIN_HI;
                else if (src == '0)
                    chk_code = ST_DIV_RANGE;
            end
            KIND_INT:
            begin
                if (rq_reg.frequency == '0)
                    chk_code = ST_INT_RANGE;
            end
            KIND_FRAC:
            begin
                if (rq_reg.frequency == '0)
                    chk_code = ST_UNREACH;
            end
            default: chk_code = ST_OK;
        endcase
    end

    // ---- divider operands
    always_comb
    begin
        case (kind_reg)
            KIND_PLL:
            begin
                dvd = {rq_reg.frequency, {FRAC_W{1'b0}}};
                dvs = DVS_W'(src);
            end
            KIND_INT:
            begin
                dvd = DVD_W'(pll_sel);
                dvs = DVS_W'(rq_reg.frequency);
            end
            default:
            begin
                dvd = {pll_sel, {FRAC_W{1'b0}}};
                dvs = fr_reg;
            end
        endcase
    end

    csdc_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (qt)
    );

    // ---- fractional encoding: q = floor(128*b / C), r = 128*b - C*q
    assign fb_a    = qt[DVD_W-1:FRAC_W];
    assign fb_b    = qt[FRAC_W-1:0];
    assign q0      = fb_b[19:13];
    assign r0      = {1'b0, fb_b[12:0], 7'b0} + 21'(q0);
    assign r_ovf   = r0 >= DEN_C;
    assign qf      = 8'(q0) + 8'(r_ovf);
    assign rf      = r_ovf ? (r0 - DEN_C) : r0;
    assign p1_frac = {fb_a[10:0], 7'b0} + 18'(qf) - P1_OFS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pll_reg[0] <= '0;
            pll_reg[1] <= '0;
        end
        else if (cmd.load_out && kind_reg == KIND_PLL && st_reg == ST_OK)
        begin
            pll_reg[rq_reg.target[0]] <= rq_reg.frequency;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            rq_reg   <= req_data;
            pre_reg  <= pre_cur;
            hi_reg   <= hi_cur;
            kind_reg <= kind_cur;
        end

        if (cmd.check)
        begin
            st_reg   <= chk_code;
            rlog_reg <= '0;
            fr_reg   <= DVS_W'(rq_reg.frequency);
        end
        else if (cmd.set_unreach)
        begin
            st_reg <= ST_UNREACH;
        end
        else if (cmd.rdiv_step)
        begin
            rlog_reg <= rlog_reg + RLOG_W'(1);
            fr_reg   <= fr_reg << 1;
        end
        else if (cmd.encode)
        begin
            p1_reg <= p1_frac;
            p2_reg <= rf[19:0];
            p3_reg <= DEN_C[19:0];
            rd_reg <= '0;
            io_reg <= 1'b0;
            case (kind_reg)
                KIND_PLL:
                begin
                    if (qt < FB_MIN || qt > FB_MAX)
                        st_reg <= ST_DIV_RANGE;
                end
                KIND_INT:
                begin
                    if (qt < IDIV_MIN || qt > IDIV_MAX)
                        st_reg <= ST_INT_RANGE;
                    p1_reg <= qt[17:0];
                    p2_reg <= '0;
                    p3_reg <= '0;
                    io_reg <= 1'b1;
                end
                default:
                begin
                    rd_reg <= rlog_reg;
                end
            endcase
        end

        if (cmd.load_out)
        begin
            out_reg.status        <= st_reg;
            out_reg.prescale_log2 <= pre_reg;
            if (st_reg == ST_OK)
            begin
                out_reg.p1           <= p1_reg;
                out_reg.p2           <= p2_reg;
                out_reg.p3           <= p3_reg;
                out_reg.rdiv_log2    <= rd_reg;
                out_reg.integer_only <= io_reg;
            end
            else
            begin
                out_reg.p1           <= '0;
                out_reg.p2           <= '0;
                out_reg.p3           <= '0;
                out_reg.rdiv_log2    <= '0;
                out_reg.integer_only <= 1'b0;
            end
        end
    end

    // ---- status to the controller
    assign sts.chk_err    = chk_code != ST_OK;
    assign sts.chk_search = kind_reg == KIND_FRAC;
    assign sts.srch_pass  = !(({{(DVS_W + MS_SH - FREQ_W){1'b0}}, pll_sel}
                                >= {fr_reg, {MS_SH{1'b0}}}) || (fr_reg < R_IN_MIN));
    assign sts.rlog_last  = &rlog_reg;
    assign sts.div_done   = div_done;

    assign rsp_data = out_reg;

endmodule

// File: rtl/csdc_ctrl.sv
// ----------------------------------------------------------------------------
// Clock synth divider calculator - controller
// Sequences check, R search, division, encoding and result hand-off.
// ----------------------------------------------------------------------------
module csdc_ctrl
    import csdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  csdc_sts_t sts,
    output csdc_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SEARCH = 6'b000100,
        S_DIV    = 6'b001000,
        S_ENC    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.chk_err)
                    state_next = S_OUT;
                else if (sts.chk_search)
                    state_next = S_SEARCH;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_SEARCH:
            begin
                if (sts.srch_pass)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (sts.rlog_last)
                begin
                    cmd.set_unreach = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.rdiv_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_ENC;
            end
            S_ENC:
            begin
                cmd.encode = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/clock_synth_divider_calculator.sv
// ----------------------------------------------------------------------------
// Clock synth divider calculator
// Computes PLL feedback and output multisynth divider parameters per request.
// ----------------------------------------------------------------------------
// Sequence: an early reject goes from acceptance straight to the output load;
//   a PLL or integer request runs the serial divide, encode and output load;
//   a fractional output first runs an R search over up to 8 R values.
// Flow: one request in flight; the next word is taken in the cycle after its
//   result is loaded.
// Reset: asynchronous active-low; 25 MHz crystal, 10 MHz clock in, PLLs zero.
// ----------------------------------------------------------------------------
module clock_synth_divider_calculator
    import csdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_word_t             req_data,

    // result channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_word_t             rsp_data,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    csdc_cmd_t cmd;
    csdc_sts_t sts;

    // Configuration writes are registered directly; the user is to issue them only
    // while the block is idle (not enforced by the block), so the port never pushes back.
    assign cfg_ready = 1'b1;

    // Controller: walks each request word through check, R search (fractional
    // outputs only), divide, encode, then waits for the output register to drain
    // before taking the next word. A finished result sits in the output
    // register while the next request is already being worked on.
    csdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: configuration, prescaler, range checks, R divider search,
    // the shared serial divider, divider encoding and the PLL frequency store.
    csdc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_data  (rsp_data)
    );

endmodule
